// File: rtl/per_slot_event_rate_checker_defines.svh
// Assertion macros shared by the per-slot event rate checker RTL.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef PER_SLOT_EVENT_RATE_CHECKER_DEFINES_SVH
`define PER_SLOT_EVENT_RATE_CHECKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSERC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSERC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pserc_pkg.sv
// Package for the per-slot event rate checker: field widths, defaults,
// event codes, register indexes and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pserc_pkg;

    localparam int FUNC_W      = 3;
    localparam int SLOT_W      = 10;
    localparam int SKILL_W     = 16;
    localparam int EIDX_W      = 4;
    localparam int ELIM_W      = 8;
    localparam int ATK_LIM_W   = 8;
    localparam int ECNT_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COUNT_BITS = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_CONNECT = 3'd0,
        FN_TICK    = 3'd1,
        FN_ATTACK  = 3'd2,
        FN_SKILL   = 3'd3,
        FN_TABLE   = 3'd4
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE       = 2'd0,
        REG_ATTACK_LIMIT = 2'd1,
        REG_ENTRY_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_WB
    } state_t;

endpackage

`default_nettype wire

// File: rtl/per_slot_event_rate_checker.sv
// Top level of the per-slot event rate checker: sequencer, config registers,
// output register. Uses pserc_pkg, pserc_ram and the assertion macro header.
//
// One event beat in, one result beat out. Slot state (attack count, skill
// count, kicked flag) lives in a SLOTS-deep RAM and the skill table in an
// ENTRIES-deep RAM, both with registered reads; every event reads its slot,
// and writes it back only while active with the slot in range, never for a
// table write. After reset the block sweeps the slot RAM to zero, one slot per
// cycle, so in_ready stays low until the sweep ends; config writes are taken
// during the sweep. An event then passes through IDLE, where it is accepted,
// LOAD and WB, and its result is registered from WB; a skill use compares up
// to min(entry_count, ENTRIES) entries in LOAD and WALK, as the table RAM is
// walked one entry per cycle through its single read port. A result waiting in
// the output register holds the sequencer only in WB.
`timescale 1ns / 1ps
`default_nettype none
`include "per_slot_event_rate_checker_defines.svh"

module per_slot_event_rate_checker
    import pserc_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [SLOT_W-1:0]     slot,
    input  wire logic [SKILL_W-1:0]    skill_id,
    input  wire logic                  both_players,
    input  wire logic                  self_target,
    input  wire logic                  has_skill,
    input  wire logic [EIDX_W-1:0]     entry_index,
    input  wire logic [ELIM_W-1:0]     entry_limit,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       kick,
    output logic [SLOT_W-1:0]          out_slot,
    output logic [COUNT_BITS-1:0]      attack_count,
    output logic [COUNT_BITS-1:0]      skill_count
);

    localparam int SAW = $clog2(SLOTS);
    localparam int CB  = COUNT_BITS;
    localparam int SW  = 2 * CB + 1;
    localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ECW = $clog2(ENTRIES + 1);
    localparam int TW  = SKILL_W + ELIM_W;

    // Configuration registers
    logic                 active_reg;
    logic [ATK_LIM_W-1:0] attack_limit_reg;
    logic [ECNT_W-1:0]    entry_count_reg;

    // Captured event
    func_t                item_func_reg;
    logic [SLOT_W-1:0]    item_slot_reg;
    logic                 item_slot_ok_reg;
    logic [SKILL_W-1:0]   item_skill_reg;
    logic                 item_attack_ok_reg;
    logic [EIDX_W-1:0]    item_eidx_reg;
    logic [ELIM_W-1:0]    item_elim_reg;

    // Sequencer and working state
    state_t               state_reg, state_next;
    logic [SAW-1:0]       clr_addr_reg, clr_addr_next;
    logic [ECW-1:0]       tbl_addr_reg, tbl_addr_next;
    logic [CB-1:0]        att_reg, att_next;
    logic [CB-1:0]        skl_reg, skl_next;
    logic                 kck_reg, kck_next;
    logic                 kick_reg, kick_next;
    logic                 wen_reg, wen_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kick_reg, out_kick_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [CB-1:0]        out_att_reg, out_att_next;
    logic [CB-1:0]        out_skl_reg, out_skl_next;

    // RAM ports
    logic                 slot_we;
    logic [SAW-1:0]       slot_waddr;
    logic [SAW-1:0]       slot_raddr;
    logic [SW-1:0]        slot_wdata;
    logic [SW-1:0]        slot_rdata;
    logic                 tbl_we;
    logic [TW-1:0]        tbl_rdata;

    logic                 in_ready_c;
    logic                 in_accept;

    // Slot and table read data
    logic [CB-1:0]        ram_att;
    logic [CB-1:0]        ram_skl;
    logic                 ram_kck;
    logic [SKILL_W-1:0]   tbl_id;
    logic [ELIM_W-1:0]    tbl_lim;

    // One skill table compare step
    logic [CB-1:0]        cur_skl;
    logic                 cur_kck;
    logic                 cur_kick;
    logic                 do_cmp;
    logic                 hit;
    logic [CB-1:0]        skl_inc;
    logic [CB-1:0]        stp_skl;
    logic                 stp_trip;
    logic                 walk_more;

    pserc_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    pserc_ram #(
        .WIDTH (TW),
        .DEPTH (ENTRIES)
    ) u_table_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (EAW'(item_eidx_reg)),
        .wdata ({item_skill_reg, item_elim_reg}),
        .raddr (tbl_addr_reg[EAW-1:0]),
        .rdata (tbl_rdata)
    );

    assign ram_att = slot_rdata[SW-1 -: CB];
    assign ram_skl = slot_rdata[CB:1];
    assign ram_kck = slot_rdata[0];
    assign tbl_id  = tbl_rdata[TW-1 -: SKILL_W];
    assign tbl_lim = tbl_rdata[ELIM_W-1:0];

    assign in_accept = in_valid && in_ready_c;

    // Entry tbl_addr_reg - 1 is on the table read data in LOAD and WALK;
    // in LOAD the counts still come straight from the slot RAM.
    assign cur_skl   = (state_reg == ST_LOAD) ? ram_skl : skl_reg;
    assign cur_kck   = (state_reg == ST_LOAD) ? ram_kck : kck_reg;
    assign cur_kick  = (state_reg == ST_LOAD) ? 1'b0    : kick_reg;
    assign do_cmp    = (state_reg == ST_WALK) || (entry_count_reg != '0);
    assign hit       = do_cmp && (tbl_id == item_skill_reg);
    assign skl_inc   = (cur_skl == '1) ? cur_skl : cur_skl + 1'b1;
    assign stp_skl   = hit ? skl_inc : cur_skl;
    assign stp_trip  = hit && (32'(skl_inc) > 32'(tbl_lim)) && !cur_kck;
    assign walk_more = (32'(tbl_addr_reg) < 32'(entry_count_reg)) &&
                       (32'(tbl_addr_reg) < ENTRIES);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            attack_limit_reg <= '0;
            entry_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACTIVE:       active_reg       <= cfg_data[0];
                REG_ATTACK_LIMIT: attack_limit_reg <= cfg_data[ATK_LIM_W-1:0];
                REG_ENTRY_COUNT:  entry_count_reg  <= cfg_data[ECNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the event beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_func_reg      <= func_t'(func);
            item_slot_reg      <= slot;
            item_slot_ok_reg   <= (32'(slot) < SLOTS);
            item_skill_reg     <= skill_id;
            item_attack_ok_reg <= both_players && !self_target && !has_skill;
            item_eidx_reg      <= entry_index;
            item_elim_reg      <= entry_limit;
        end
    end

    // Working counts and output payload
    always_ff @(posedge clk)
    begin
        att_reg      <= att_next;
        skl_reg      <= skl_next;
        kck_reg      <= kck_next;
        kick_reg     <= kick_next;
        out_kick_reg <= out_kick_next;
        out_slot_reg <= out_slot_next;
        out_att_reg  <= out_att_next;
        out_skl_reg  <= out_skl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            tbl_addr_reg  <= '0;
            wen_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            tbl_addr_reg  <= tbl_addr_next;
            wen_reg       <= wen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        tbl_addr_next  = tbl_addr_reg;
        att_next       = att_reg;
        skl_next       = skl_reg;
        kck_next       = kck_reg;
        kick_next      = kick_reg;
        wen_next       = wen_reg;
        out_valid_next = out_valid_reg;
        out_kick_next  = out_kick_reg;
        out_slot_next  = out_slot_reg;
        out_att_next   = out_att_reg;
        out_skl_next   = out_skl_reg;
        in_ready_c     = 1'b0;
        slot_we        = 1'b0;
        slot_waddr     = SAW'(item_slot_reg);
        slot_raddr     = SAW'(slot);
        slot_wdata     = {att_reg, skl_reg, kck_reg};
        tbl_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one slot per cycle
                slot_we    = 1'b1;
                slot_waddr = clr_addr_reg;
                slot_wdata = '0;
                if (clr_addr_reg == SAW'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                in_ready_c = 1'b1;
                if (in_valid)
                begin
                    // Entry 0 is read this cycle; advance to entry 1
                    tbl_addr_next = ECW'(1);
                    state_next    = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                tbl_addr_next = tbl_addr_reg + 1'b1;
                att_next      = ram_att;
                skl_next      = ram_skl;
                kck_next      = ram_kck;
                kick_next     = 1'b0;
                wen_next      = 1'b0;
                state_next    = ST_WB;
                if (item_func_reg == FN_TABLE)
                begin
                    tbl_we = (32'(item_eidx_reg) < ENTRIES);
                end
                else if (active_reg && item_slot_ok_reg)
                begin
                    case (item_func_reg)
                        FN_CONNECT:
                        begin
                            att_next = '0;
                            skl_next = '0;
                            kck_next = 1'b0;
                            wen_next = 1'b1;
                        end
                        FN_TICK:
                        begin
                            if ((32'(ram_att) > 32'(attack_limit_reg)) && !ram_kck)
                            begin
                                kck_next  = 1'b1;
                                kick_next = 1'b1;
                            end
                            att_next = '0;
                            skl_next = '0;
                            wen_next = 1'b1;
                        end
                        FN_ATTACK:
                        begin
                            if (item_attack_ok_reg)
                            begin
                                att_next = (ram_att == '1) ? ram_att : ram_att + 1'b1;
                                wen_next = 1'b1;
                            end
                        end
                        FN_SKILL:
                        begin
                            skl_next  = stp_skl;
                            kck_next  = cur_kck | stp_trip;
                            kick_next = cur_kick | stp_trip;
                            wen_next  = 1'b1;
                            if (walk_more)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                tbl_addr_next = tbl_addr_reg + 1'b1;
                skl_next      = stp_skl;
                kck_next      = cur_kck | stp_trip;
                kick_next     = cur_kick | stp_trip;
                if (!walk_more)
                begin
                    state_next = ST_WB;
                end
            end

            ST_WB:
            begin
                // Write back every cycle while the result waits; the data holds
                slot_we = wen_reg;
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_kick_next  = kick_reg;
                    out_slot_next  = item_slot_reg;
                    out_att_next   = item_slot_ok_reg ? att_reg : '0;
                    out_skl_next   = item_slot_ok_reg ? skl_reg : '0;
                    tbl_addr_next  = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready     = in_ready_c;
    assign out_valid    = out_valid_reg;
    assign kick         = out_kick_reg;
    assign out_slot     = out_slot_reg;
    assign attack_count = out_att_reg;
    assign skill_count  = out_skl_reg;

    `PSERC_ASSERT_NEXT(a_accept_loads, in_accept, state_reg == ST_LOAD, "accepted beat did not start a slot read")
    `PSERC_ASSERT_NOW(a_walk_no_wb, state_reg == ST_WALK, !slot_we, "slot RAM written during table walk")
    `PSERC_ASSERT_NOW(a_walk_is_skill, state_reg == ST_WALK, item_func_reg == FN_SKILL, "table walk for a non-skill event")
    `PSERC_ASSERT_NOW(a_clear_blocks, state_reg == ST_CLEAR, !in_ready && slot_we, "event taken or no write during clearing sweep")

endmodule

`default_nettype wire

// File: rtl/pserc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pserc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
